// ----- rtl/offt_pkg.sv -----
// ----------------------------------------------------------------------------
// offt_pkg
// Shared types, codes and sizes of the OBJ face fan triangulator.
// ----------------------------------------------------------------------------
package offt_pkg;

    localparam int POS_DEPTH  = 4096;
    localparam int NORM_DEPTH = 4096;
    localparam int POS_AW     = $clog2(POS_DEPTH);
    localparam int NORM_AW    = $clog2(NORM_DEPTH);
    localparam int POS_CW     = $clog2(POS_DEPTH + 1);
    localparam int NORM_CW    = $clog2(NORM_DEPTH + 1);
    localparam int MAX_AW     = (POS_AW > NORM_AW) ? POS_AW : NORM_AW;
    localparam int RAW_W      = 14;
    localparam int RES_W      = ((MAX_AW > RAW_W) ? MAX_AW : RAW_W) + 2;

    localparam int COORD_W    = 32;
    localparam int VEC_W      = 3 * COORD_W;

    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam int DIV_STEPS  = 18;
    localparam int SQRT_STEPS = 32;

    localparam logic [1:0] CMD_ADD_POS  = 2'd0;
    localparam logic [1:0] CMD_ADD_NORM = 2'd1;
    localparam logic [1:0] CMD_FACE     = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_POS  = 3'd1;
    localparam logic [2:0] ST_BAD_NORM = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // one queued word: a triangle, an error status and/or a short-face status
    typedef struct packed {
        logic                          tri_valid;
        logic [2:0][POS_AW-1:0]        pidx;
        logic [2:0][NORM_AW-1:0]       nidx;
        logic                          stored;
        logic [2:0]                    err;
        logic                          short_face;
    } op_t;

    typedef struct packed {
        logic             ok;
        logic [RES_W-1:0] idx;
    } res_t;

    // resolve a raw OBJ index against a store size
    function automatic res_t resolve(input logic signed [RAW_W-1:0] raw,
                                     input logic [RES_W-1:0] size);
        logic signed [RES_W-1:0] r;
        logic signed [RES_W-1:0] s;
        logic signed [RES_W-1:0] idx;
        res_t                    o;
        r = RES_W'(raw);
        s = $signed(size);
        idx = (raw < 0) ? (s + r) : (r - RES_W'(1));
        o.ok  = (idx >= 0) && (idx < s);
        o.idx = idx;
        return o;
    endfunction

endpackage

// ----- rtl/offt_if.sv -----
// ----------------------------------------------------------------------------
// offt_in_if / offt_out_if
// Valid/ready channels for mesh items and corner results.
// ----------------------------------------------------------------------------
interface offt_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic signed [31:0]  coord_z;
    logic signed [13:0]  pos_index;
    logic                has_normal;
    logic signed [13:0]  norm_index;
    logic                end_of_face;

    modport source (output valid, cmd, coord_x, coord_y, coord_z, pos_index,
                    has_normal, norm_index, end_of_face, input ready);
    modport sink   (input valid, cmd, coord_x, coord_y, coord_z, pos_index,
                    has_normal, norm_index, end_of_face, output ready);
endinterface

interface offt_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  vertex_x;
    logic signed [31:0]  vertex_y;
    logic signed [31:0]  vertex_z;
    logic signed [31:0]  normal_out_x;
    logic signed [31:0]  normal_out_y;
    logic signed [31:0]  normal_out_z;
    logic                triangle_end;
    logic [2:0]          status;

    modport source (output valid, vertex_x, vertex_y, vertex_z, normal_out_x,
                    normal_out_y, normal_out_z, triangle_end, status, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, normal_out_x,
                    normal_out_y, normal_out_z, triangle_end, status, output ready);
endinterface

// ----- rtl/offt_ram.sv -----
// ----------------------------------------------------------------------------
// offt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module offt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/offt_front.sv -----
// ----------------------------------------------------------------------------
// offt_front
// Accepts mesh items, writes the stores, resolves face indices and queues work.
// ----------------------------------------------------------------------------
module offt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    offt_in_if.sink                        in,
    output offt_pkg::op_t                  q_data,
    output logic                           q_push,
    input  logic                           q_full,
    output logic                           pos_we,
    output logic [offt_pkg::POS_AW-1:0]    pos_waddr,
    output logic [offt_pkg::VEC_W-1:0]     pos_wdata,
    output logic                           norm_we,
    output logic [offt_pkg::NORM_AW-1:0]   norm_waddr,
    output logic [offt_pkg::VEC_W-1:0]     norm_wdata
);

    logic [offt_pkg::POS_CW-1:0]  pcount_reg, pcount_next;
    logic [offt_pkg::NORM_CW-1:0] ncount_reg, ncount_next;
    logic [offt_pkg::POS_AW-1:0]  first_pos_reg, first_pos_next;
    logic [offt_pkg::POS_AW-1:0]  prev_pos_reg, prev_pos_next;
    logic [offt_pkg::NORM_AW-1:0] first_norm_reg, first_norm_next;
    logic [offt_pkg::NORM_AW-1:0] prev_norm_reg, prev_norm_next;
    logic                         first_nv_reg, first_nv_next;
    logic                         prev_nv_reg, prev_nv_next;
    logic [1:0]                   fvc_reg, fvc_next;
    logic                         dead_reg, dead_next;

    logic                         acc;
    offt_pkg::res_t               pres;
    offt_pkg::res_t               nres;
    logic [offt_pkg::POS_AW-1:0]  np;
    logic [offt_pkg::NORM_AW-1:0] nn;

    assign in.ready  = !q_full;
    assign acc       = in.valid && in.ready;
    assign pos_waddr  = pcount_reg[offt_pkg::POS_AW-1:0];
    assign norm_waddr = ncount_reg[offt_pkg::NORM_AW-1:0];
    assign pos_wdata  = {in.coord_x, in.coord_y, in.coord_z};
    assign norm_wdata = {in.coord_x, in.coord_y, in.coord_z};

    assign pres = offt_pkg::resolve(in.pos_index, offt_pkg::RES_W'(pcount_reg));
    assign nres = offt_pkg::resolve(in.norm_index, offt_pkg::RES_W'(ncount_reg));
    assign np   = pres.idx[offt_pkg::POS_AW-1:0];
    assign nn   = in.has_normal ? nres.idx[offt_pkg::NORM_AW-1:0] : '0;

    always_comb
    begin
        pcount_next     = pcount_reg;
        ncount_next     = ncount_reg;
        first_pos_next  = first_pos_reg;
        prev_pos_next   = prev_pos_reg;
        first_norm_next = first_norm_reg;
        prev_norm_next  = prev_norm_reg;
        first_nv_next   = first_nv_reg;
        prev_nv_next    = prev_nv_reg;
        fvc_next        = fvc_reg;
        dead_next       = dead_reg;
        pos_we          = 1'b0;
        norm_we         = 1'b0;
        q_data          = '0;
        q_data.pidx     = {np, prev_pos_reg, first_pos_reg};
        q_data.nidx     = {nn, prev_norm_reg, first_norm_reg};
        q_data.stored   = first_nv_reg && prev_nv_reg && in.has_normal;

        if (acc)
        begin
            case (in.cmd)
                offt_pkg::CMD_ADD_POS:
                begin
                    if (pcount_reg >= offt_pkg::POS_CW'(offt_pkg::POS_DEPTH))
                    begin
                        q_data.err = offt_pkg::ST_FULL;
                    end
                    else
                    begin
                        pos_we      = 1'b1;
                        pcount_next = pcount_reg + 1'b1;
                    end
                end
                offt_pkg::CMD_ADD_NORM:
                begin
                    if (ncount_reg >= offt_pkg::NORM_CW'(offt_pkg::NORM_DEPTH))
                    begin
                        q_data.err = offt_pkg::ST_FULL;
                    end
                    else
                    begin
                        norm_we     = 1'b1;
                        ncount_next = ncount_reg + 1'b1;
                    end
                end
                offt_pkg::CMD_FACE:
                begin
                    if (!dead_reg)
                    begin
                        if (!pres.ok)
                        begin
                            q_data.err = offt_pkg::ST_BAD_POS;
                            dead_next  = 1'b1;
                        end
                        else if (in.has_normal && !nres.ok)
                        begin
                            q_data.err = offt_pkg::ST_BAD_NORM;
                            dead_next  = 1'b1;
                        end
                        else
                        begin
                            if (fvc_reg == 2'd0)
                            begin
                                first_pos_next  = np;
                                first_norm_next = nn;
                                first_nv_next   = in.has_normal;
                            end
                            else if (fvc_reg >= 2'd2)
                            begin
                                q_data.tri_valid = 1'b1;
                            end
                            prev_pos_next  = np;
                            prev_norm_next = nn;
                            prev_nv_next   = in.has_normal;
                            if (fvc_reg != 2'd3)
                            begin
                                fvc_next = fvc_reg + 2'd1;
                            end
                        end
                    end
                    if (in.end_of_face)
                    begin
                        q_data.short_face = (fvc_next != 2'd3);
                        fvc_next        = 2'd0;
                        dead_next       = 1'b0;
                        first_pos_next  = '0;
                        prev_pos_next   = '0;
                        first_norm_next = '0;
                        prev_norm_next  = '0;
                        first_nv_next   = 1'b0;
                        prev_nv_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        q_push = acc && (q_data.tri_valid || (q_data.err != offt_pkg::ST_OK)
                         || q_data.short_face);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg     <= '0;
            ncount_reg     <= '0;
            first_pos_reg  <= '0;
            prev_pos_reg   <= '0;
            first_norm_reg <= '0;
            prev_norm_reg  <= '0;
            first_nv_reg   <= 1'b0;
            prev_nv_reg    <= 1'b0;
            fvc_reg        <= '0;
            dead_reg       <= 1'b0;
        end
        else
        begin
            pcount_reg     <= pcount_next;
            ncount_reg     <= ncount_next;
            first_pos_reg  <= first_pos_next;
            prev_pos_reg   <= prev_pos_next;
            first_norm_reg <= first_norm_next;
            prev_norm_reg  <= prev_norm_next;
            first_nv_reg   <= first_nv_next;
            prev_nv_reg    <= prev_nv_next;
            fvc_reg        <= fvc_next;
            dead_reg       <= dead_next;
        end
    end

endmodule

// ----- rtl/offt_queue.sv -----
// ----------------------------------------------------------------------------
// offt_queue
// Short FIFO of work words between the front and back parts.
// ----------------------------------------------------------------------------
module offt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  offt_pkg::op_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output offt_pkg::op_t head
);

    offt_pkg::op_t                entry_reg [offt_pkg::QDEPTH];
    logic [offt_pkg::QAW-1:0]     wp_reg;
    logic [offt_pkg::QAW-1:0]     rp_reg;
    logic [offt_pkg::QAW:0]       cnt_reg;

    assign full  = (cnt_reg == (offt_pkg::QAW+1)'(offt_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/offt_back.sv -----
// ----------------------------------------------------------------------------
// offt_back
// Reads corners, works out the face normal with a shared multiplier, an
// iterative square root and a restoring divider, and sends corner results.
// ----------------------------------------------------------------------------
module offt_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  offt_pkg::op_t                  q_head,
    output logic                           q_pop,
    output logic [offt_pkg::POS_AW-1:0]    pos_raddr,
    input  logic [offt_pkg::VEC_W-1:0]     pos_rdata,
    output logic [offt_pkg::NORM_AW-1:0]   norm_raddr,
    input  logic [offt_pkg::VEC_W-1:0]     norm_rdata,
    offt_out_if.source                     out
);

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_RDP    = 4'd1;
    localparam logic [3:0] B_RDN    = 4'd2;
    localparam logic [3:0] B_EDGE   = 4'd3;
    localparam logic [3:0] B_MUL    = 4'd4;
    localparam logic [3:0] B_MAG    = 4'd5;
    localparam logic [3:0] B_NORM   = 4'd6;
    localparam logic [3:0] B_SQ     = 4'd7;
    localparam logic [3:0] B_SQRT   = 4'd8;
    localparam logic [3:0] B_DIVI   = 4'd9;
    localparam logic [3:0] B_DIV    = 4'd10;
    localparam logic [3:0] B_CORNER = 4'd11;
    localparam logic [3:0] B_ERR    = 4'd12;
    localparam logic [3:0] B_SHORT  = 4'd13;

    logic [3:0]                   state_reg;
    offt_pkg::op_t                op_reg;
    logic [1:0]                   rcnt_reg;
    logic [2:0]                   step_reg;
    logic [4:0]                   scnt_reg;
    logic [1:0]                   comp_reg;
    logic [offt_pkg::VEC_W-1:0]   p_reg  [3];
    logic [offt_pkg::VEC_W-1:0]   n_reg  [3];
    logic signed [31:0]           e_reg  [6];
    logic signed [63:0]           prod_reg;
    logic signed [63:0]           cr_reg [3];
    logic [61:0]                  cm_reg [3];
    logic [2:0]                   cn_reg;
    logic [61:0]                  sq_reg;
    logic [63:0]                  sum_reg;
    logic [63:0]                  v_reg;
    logic [63:0]                  res_reg;
    logic [62:0]                  bit_reg;
    logic [31:0]                  len_reg;
    logic [31:0]                  rem_reg;
    logic [offt_pkg::DIV_STEPS-1:0] nlo_reg;
    logic [offt_pkg::DIV_STEPS-1:0] q_reg;
    logic [offt_pkg::VEC_W-1:0]   fn_reg;
    logic                         ov_reg;
    logic [offt_pkg::VEC_W-1:0]   ovtx_reg;
    logic [offt_pkg::VEC_W-1:0]   onrm_reg;
    logic                         otend_reg;
    logic [2:0]                   ostat_reg;

    logic                         can_emit;
    logic                         load_out;
    logic signed [32:0]           ediff [6];
    logic [32:0]                  emag  [6];
    logic [32:0]                  emax;
    logic [1:0]                   eshift;
    logic signed [31:0]           ma, mb;
    logic [61:0]                  cmax;
    logic [30:0]                  sqop;
    logic [63:0]                  rb;
    logic [47:0]                  num;
    logic [32:0]                  rem2;
    logic [31:0]                  qs;

    assign can_emit = !ov_reg || out.ready;
    assign load_out = can_emit && (((state_reg == B_CORNER) && (comp_reg != 2'd3))
                                   || (state_reg == B_ERR) || (state_reg == B_SHORT));
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    assign out.valid        = ov_reg;
    assign out.vertex_x     = ovtx_reg[95:64];
    assign out.vertex_y     = ovtx_reg[63:32];
    assign out.vertex_z     = ovtx_reg[31:0];
    assign out.normal_out_x = onrm_reg[95:64];
    assign out.normal_out_y = onrm_reg[63:32];
    assign out.normal_out_z = onrm_reg[31:0];
    assign out.triangle_end = otend_reg;
    assign out.status       = ostat_reg;

    assign pos_raddr  = op_reg.pidx[rcnt_reg];
    assign norm_raddr = op_reg.nidx[rcnt_reg];

    // edges from the first corner, scaled together below 2^30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ediff[i]     = 33'($signed(p_reg[1][95-32*i -: 32]))
                         - 33'($signed(p_reg[0][95-32*i -: 32]));
            ediff[i + 3] = 33'($signed(p_reg[2][95-32*i -: 32]))
                         - 33'($signed(p_reg[0][95-32*i -: 32]));
        end
        emax = '0;
        for (int i = 0; i < 6; i++)
        begin
            emag[i] = ediff[i][32] ? 33'(-ediff[i]) : 33'(ediff[i]);
            if (emag[i] > emax)
            begin
                emax = emag[i];
            end
        end
        if (emax[32])
        begin
            eshift = 2'd3;
        end
        else if (emax[31])
        begin
            eshift = 2'd2;
        end
        else if (emax[30])
        begin
            eshift = 2'd1;
        end
        else
        begin
            eshift = 2'd0;
        end
    end

    // multiplier operands for the six cross-product terms
    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = e_reg[1]; mb = e_reg[5]; end
            3'd1:    begin ma = e_reg[2]; mb = e_reg[4]; end
            3'd2:    begin ma = e_reg[2]; mb = e_reg[3]; end
            3'd3:    begin ma = e_reg[0]; mb = e_reg[5]; end
            3'd4:    begin ma = e_reg[0]; mb = e_reg[4]; end
            3'd5:    begin ma = e_reg[1]; mb = e_reg[3]; end
            default: begin ma = '0;       mb = '0;       end
        endcase
    end

    always_comb
    begin
        cmax = cm_reg[0];
        if (cm_reg[1] > cmax)
        begin
            cmax = cm_reg[1];
        end
        if (cm_reg[2] > cmax)
        begin
            cmax = cm_reg[2];
        end
        case (step_reg)
            3'd0:    sqop = cm_reg[0][30:0];
            3'd1:    sqop = cm_reg[1][30:0];
            3'd2:    sqop = cm_reg[2][30:0];
            default: sqop = '0;
        endcase
        rb   = res_reg + 64'(bit_reg);
        num  = {1'b0, cm_reg[comp_reg][30:0], 16'b0} + 48'(len_reg[31:1]);
        rem2 = {rem_reg, nlo_reg[offt_pkg::DIV_STEPS-1]};
        qs   = 32'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                op_reg <= q_head;
            end
            B_RDP:
            begin
                if (rcnt_reg != 2'd0)
                begin
                    p_reg[rcnt_reg - 2'd1] <= pos_rdata;
                end
            end
            B_RDN:
            begin
                if (rcnt_reg != 2'd0)
                begin
                    n_reg[rcnt_reg - 2'd1] <= norm_rdata;
                end
            end
            B_EDGE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    e_reg[i] <= ediff[i][32] ? -$signed(32'(emag[i] >> eshift))
                                             : $signed(32'(emag[i] >> eshift));
                end
                for (int i = 0; i < 3; i++)
                begin
                    cr_reg[i] <= '0;
                end
                fn_reg <= '0;
            end
            B_MUL:
            begin
                prod_reg <= 64'(ma) * 64'(mb);
                case (step_reg)
                    3'd1:    cr_reg[0] <= cr_reg[0] + prod_reg;
                    3'd2:    cr_reg[0] <= cr_reg[0] - prod_reg;
                    3'd3:    cr_reg[1] <= cr_reg[1] + prod_reg;
                    3'd4:    cr_reg[1] <= cr_reg[1] - prod_reg;
                    3'd5:    cr_reg[2] <= cr_reg[2] + prod_reg;
                    3'd6:    cr_reg[2] <= cr_reg[2] - prod_reg;
                    default: begin end
                endcase
            end
            B_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cn_reg[i] <= cr_reg[i][63];
                    cm_reg[i] <= cr_reg[i][63] ? 62'(-cr_reg[i]) : 62'(cr_reg[i]);
                end
                sum_reg <= '0;
            end
            B_NORM:
            begin
                // walk the largest magnitude into [2^30, 2^31)
                for (int i = 0; i < 3; i++)
                begin
                    if (cmax >= 62'h8000_0000)
                    begin
                        cm_reg[i] <= cm_reg[i] >> 1;
                    end
                    else if (cmax < 62'h4000_0000)
                    begin
                        cm_reg[i] <= cm_reg[i] << 1;
                    end
                end
            end
            B_SQ:
            begin
                sq_reg <= 62'(sqop) * 62'(sqop);
                if (step_reg != 3'd0)
                begin
                    sum_reg <= sum_reg + 64'(sq_reg);
                end
                v_reg   <= sum_reg + 64'(sq_reg);
                res_reg <= '0;
                bit_reg <= {1'b1, 62'b0};
            end
            B_SQRT:
            begin
                // len follows the new root so it is final on the last step
                if (v_reg >= rb)
                begin
                    v_reg   <= v_reg - rb;
                    res_reg <= (res_reg >> 1) + 64'(bit_reg);
                    len_reg <= 32'((res_reg >> 1) + 64'(bit_reg));
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                    len_reg <= 32'(res_reg >> 1);
                end
                bit_reg <= bit_reg >> 2;
            end
            B_DIVI:
            begin
                rem_reg <= 32'(num[47:offt_pkg::DIV_STEPS]);
                nlo_reg <= num[offt_pkg::DIV_STEPS-1:0];
                q_reg   <= '0;
            end
            B_DIV:
            begin
                if (rem2 >= 33'(len_reg))
                begin
                    rem_reg <= 32'(rem2 - 33'(len_reg));
                    q_reg   <= {q_reg[offt_pkg::DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[31:0];
                    q_reg   <= {q_reg[offt_pkg::DIV_STEPS-2:0], 1'b0};
                end
                nlo_reg <= nlo_reg << 1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == B_DIVI && comp_reg != 2'd0)
        begin
            // the previous quotient is complete: store it with its sign
            fn_reg[95-32*(comp_reg-2'd1) -: 32] <= cn_reg[comp_reg - 2'd1] ? -qs : qs;
        end
        if (state_reg == B_CORNER && comp_reg == 2'd3)
        begin
            fn_reg[31:0] <= cn_reg[2] ? -qs : qs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            rcnt_reg  <= '0;
            step_reg  <= '0;
            scnt_reg  <= '0;
            comp_reg  <= '0;
            ov_reg    <= 1'b0;
            ovtx_reg  <= '0;
            onrm_reg  <= '0;
            otend_reg <= 1'b0;
            ostat_reg <= offt_pkg::ST_OK;
        end
        else
        begin
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    rcnt_reg <= '0;
                    step_reg <= '0;
                    comp_reg <= '0;
                    if (!q_empty)
                    begin
                        if (q_head.tri_valid)
                        begin
                            state_reg <= B_RDP;
                        end
                        else if (q_head.err != offt_pkg::ST_OK)
                        begin
                            state_reg <= B_ERR;
                        end
                        else
                        begin
                            state_reg <= B_SHORT;
                        end
                    end
                end
                B_RDP:
                begin
                    if (rcnt_reg == 2'd3)
                    begin
                        rcnt_reg  <= '0;
                        state_reg <= op_reg.stored ? B_RDN : B_EDGE;
                    end
                    else
                    begin
                        rcnt_reg <= rcnt_reg + 2'd1;
                    end
                end
                B_RDN:
                begin
                    if (rcnt_reg == 2'd3)
                    begin
                        rcnt_reg  <= '0;
                        state_reg <= B_CORNER;
                    end
                    else
                    begin
                        rcnt_reg <= rcnt_reg + 2'd1;
                    end
                end
                B_EDGE:
                begin
                    step_reg  <= '0;
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    if (step_reg == 3'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= B_MAG;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                B_MAG:
                begin
                    // zero cross product keeps a zero normal
                    if (cr_reg[0] == '0 && cr_reg[1] == '0 && cr_reg[2] == '0)
                    begin
                        comp_reg  <= '0;
                        state_reg <= B_CORNER;
                    end
                    else
                    begin
                        state_reg <= B_NORM;
                    end
                end
                B_NORM:
                begin
                    if (cmax < 62'h8000_0000 && cmax >= 62'h4000_0000)
                    begin
                        step_reg  <= '0;
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd3)
                    begin
                        scnt_reg  <= '0;
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    scnt_reg <= scnt_reg + 5'd1;
                    if (scnt_reg == 5'(offt_pkg::SQRT_STEPS - 1))
                    begin
                        comp_reg  <= '0;
                        state_reg <= B_DIVI;
                    end
                end
                B_DIVI:
                begin
                    scnt_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    scnt_reg <= scnt_reg + 5'd1;
                    if (scnt_reg == 5'(offt_pkg::DIV_STEPS - 1))
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= (comp_reg == 2'd2) ? B_CORNER : B_DIVI;
                    end
                end
                B_CORNER:
                begin
                    // after the last divide, wait here while the z term lands in fn_reg
                    if (comp_reg == 2'd3)
                    begin
                        comp_reg <= '0;
                    end
                    else if (can_emit)
                    begin
                        ovtx_reg  <= p_reg[rcnt_reg];
                        onrm_reg  <= op_reg.stored ? n_reg[rcnt_reg] : fn_reg;
                        otend_reg <= (rcnt_reg == 2'd2);
                        ostat_reg <= offt_pkg::ST_OK;
                        if (rcnt_reg == 2'd2)
                        begin
                            rcnt_reg  <= '0;
                            state_reg <= op_reg.short_face ? B_SHORT : B_IDLE;
                        end
                        else
                        begin
                            rcnt_reg <= rcnt_reg + 2'd1;
                        end
                    end
                end
                B_ERR:
                begin
                    if (can_emit)
                    begin
                        ovtx_reg  <= '0;
                        onrm_reg  <= '0;
                        otend_reg <= 1'b0;
                        ostat_reg <= op_reg.err;
                        state_reg <= op_reg.short_face ? B_SHORT : B_IDLE;
                    end
                end
                B_SHORT:
                begin
                    if (can_emit)
                    begin
                        ovtx_reg  <= '0;
                        onrm_reg  <= '0;
                        otend_reg <= 1'b0;
                        ostat_reg <= offt_pkg::ST_SHORT;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/obj_face_fan_triangulator_core.sv -----
// ----------------------------------------------------------------------------
// obj_face_fan_triangulator_core
// OBJ face fan triangulator: stores positions and normals, fans faces into
// triangles and sends three corner words per triangle, plus status words.
// ----------------------------------------------------------------------------
// Adds and face vertices are taken whenever the queue has room. In the back
// part a triangle with stored normals reads positions and normals, then sends
// its corners; a zero-area one reads positions and forms the cross product; a
// computed normal adds a 32-step square root, three divides and up to 30
// one-bit shifts. Output stalls hold the back part. Reset clears counts, face
// state and queue; the stores are not cleared.
// ----------------------------------------------------------------------------
module obj_face_fan_triangulator_core (
    input  logic        clk,
    input  logic        rst_n,
    offt_in_if.sink     in,
    offt_out_if.source  out
);

    offt_pkg::op_t                q_data;
    offt_pkg::op_t                q_head;
    logic                         q_push, q_full, q_pop, q_empty;
    logic                         pos_we, norm_we;
    logic [offt_pkg::POS_AW-1:0]  pos_waddr, pos_raddr;
    logic [offt_pkg::NORM_AW-1:0] norm_waddr, norm_raddr;
    logic [offt_pkg::VEC_W-1:0]   pos_wdata, pos_rdata, norm_wdata, norm_rdata;

    offt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (in),
        .q_data     (q_data),
        .q_push     (q_push),
        .q_full     (q_full),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .norm_we    (norm_we),
        .norm_waddr (norm_waddr),
        .norm_wdata (norm_wdata)
    );

    offt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    offt_ram #(
        .WIDTH (offt_pkg::VEC_W),
        .DEPTH (offt_pkg::POS_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    offt_ram #(
        .WIDTH (offt_pkg::VEC_W),
        .DEPTH (offt_pkg::NORM_DEPTH)
    ) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (norm_waddr),
        .wdata (norm_wdata),
        .raddr (norm_raddr),
        .rdata (norm_rdata)
    );

    offt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata),
        .norm_raddr (norm_raddr),
        .norm_rdata (norm_rdata),
        .out        (out)
    );

endmodule

// ----- verif/tb_obj_face_fan_triangulator_core.sv -----
// ----------------------------------------------------------------------------
// tb_obj_face_fan_triangulator_core
// Self-checking bench for the OBJ face fan triangulator. Mesh items go in
// through a bursty sender and corner words come out into a stalling receiver.
// A scoreboard keeps its own copy of the stores and face state, works out the
// corner words for every accepted item and checks each output word in order.
// ----------------------------------------------------------------------------
module tb_obj_face_fan_triangulator_core;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic signed [31:0] nx, ny, nz;
        logic               tend;
        logic [2:0]         status;
    } corner_t;

    class fan_scoreboard;
        int          pos_x[offt_pkg::POS_DEPTH], pos_y[offt_pkg::POS_DEPTH];
        int          pos_z[offt_pkg::POS_DEPTH];
        int          nrm_x[offt_pkg::NORM_DEPTH], nrm_y[offt_pkg::NORM_DEPTH];
        int          nrm_z[offt_pkg::NORM_DEPTH];
        int          pos_cnt, nrm_cnt;
        int          first_p, prev_p, first_n, prev_n;
        bit          first_nv, prev_nv;
        int          vert_cnt;
        bit          dead;
        corner_t     corners_due[$];
        int          errors;

        function void push(int x, int y, int z, int nx, int ny, int nz,
                           bit tend, logic [2:0] st);
            corner_t c;
            c.x = x; c.y = y; c.z = z;
            c.nx = nx; c.ny = ny; c.nz = nz;
            c.tend = tend;
            c.status = st;
            corners_due.push_back(c);
        endfunction

        function int resolve_idx(int raw, int size);
            int idx;
            idx = (raw < 0) ? size + raw : raw - 1;
            return (idx < 0 || idx >= size) ? -1 : idx;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void tri_normal(int a, int b, int c, output int n[3]);
            longint          e[6];
            longint unsigned m[6];
            longint unsigned mx, cmax, sum, len, qv;
            bit              ng[6];
            longint          cr[3];
            longint unsigned cm[3];
            bit              cn[3];
            int              s;
            e[0] = longint'(pos_x[b]) - pos_x[a];
            e[1] = longint'(pos_y[b]) - pos_y[a];
            e[2] = longint'(pos_z[b]) - pos_z[a];
            e[3] = longint'(pos_x[c]) - pos_x[a];
            e[4] = longint'(pos_y[c]) - pos_y[a];
            e[5] = longint'(pos_z[c]) - pos_z[a];
            mx = 0;
            for (int i = 0; i < 6; i++)
            begin
                ng[i] = e[i] < 0;
                m[i] = ng[i] ? -e[i] : e[i];
                if (m[i] > mx) mx = m[i];
            end
            s = 0;
            while ((mx >> s) >= (64'd1 << 30)) s++;
            for (int i = 0; i < 6; i++)
                e[i] = ng[i] ? -longint'(m[i] >> s) : longint'(m[i] >> s);
            cr[0] = e[1] * e[5] - e[2] * e[4];
            cr[1] = e[2] * e[3] - e[0] * e[5];
            cr[2] = e[0] * e[4] - e[1] * e[3];
            cmax = 0;
            for (int i = 0; i < 3; i++)
            begin
                cn[i] = cr[i] < 0;
                cm[i] = cn[i] ? -cr[i] : cr[i];
                if (cm[i] > cmax) cmax = cm[i];
            end
            if (cmax == 0)
            begin
                n = '{0, 0, 0};
                return;
            end
            while (cmax >= (64'd1 << 31))
            begin
                cmax = cmax >> 1;
                for (int i = 0; i < 3; i++) cm[i] = cm[i] >> 1;
            end
            while (cmax < (64'd1 << 30))
            begin
                cmax = cmax << 1;
                for (int i = 0; i < 3; i++) cm[i] = cm[i] << 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += cm[i] * cm[i];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                qv = (cm[i] * 65536 + len / 2) / len;
                n[i] = cn[i] ? -int'(qv) : int'(qv);
            end
        endfunction

        function void clear_face();
            vert_cnt = 0;
            dead = 0;
            first_p = 0; prev_p = 0; first_n = 0; prev_n = 0;
            first_nv = 0; prev_nv = 0;
        endfunction

        function void note_item(logic [1:0] cmd, int cx, int cy, int cz,
                                logic signed [13:0] pidx_raw, bit hn,
                                logic signed [13:0] nidx_raw, bit eof);
            int p, n, pi[3], ni[3], fn[3];
            bit stored;
            case (cmd)
                offt_pkg::CMD_ADD_POS:
                    if (pos_cnt >= offt_pkg::POS_DEPTH)
                        push(0, 0, 0, 0, 0, 0, 0, offt_pkg::ST_FULL);
                    else
                    begin
                        pos_x[pos_cnt] = cx; pos_y[pos_cnt] = cy; pos_z[pos_cnt] = cz;
                        pos_cnt++;
                    end
                offt_pkg::CMD_ADD_NORM:
                    if (nrm_cnt >= offt_pkg::NORM_DEPTH)
                        push(0, 0, 0, 0, 0, 0, 0, offt_pkg::ST_FULL);
                    else
                    begin
                        nrm_x[nrm_cnt] = cx; nrm_y[nrm_cnt] = cy; nrm_z[nrm_cnt] = cz;
                        nrm_cnt++;
                    end
                offt_pkg::CMD_FACE:
                begin
                    if (!dead)
                    begin
                        p = resolve_idx(int'(pidx_raw), pos_cnt);
                        n = hn ? resolve_idx(int'(nidx_raw), nrm_cnt) : 0;
                        if (p < 0)
                        begin
                            push(0, 0, 0, 0, 0, 0, 0, offt_pkg::ST_BAD_POS);
                            dead = 1;
                        end
                        else if (hn && n < 0)
                        begin
                            push(0, 0, 0, 0, 0, 0, 0, offt_pkg::ST_BAD_NORM);
                            dead = 1;
                        end
                        else
                        begin
                            if (vert_cnt == 0)
                            begin
                                first_p = p; first_n = n; first_nv = hn;
                            end
                            else if (vert_cnt >= 2)
                            begin
                                pi = '{first_p, prev_p, p};
                                ni = '{first_n, prev_n, n};
                                stored = first_nv && prev_nv && hn;
                                if (!stored) tri_normal(pi[0], pi[1], pi[2], fn);
                                for (int k = 0; k < 3; k++)
                                    if (stored)
                                        push(pos_x[pi[k]], pos_y[pi[k]], pos_z[pi[k]],
                                             nrm_x[ni[k]], nrm_y[ni[k]], nrm_z[ni[k]],
                                             k == 2, offt_pkg::ST_OK);
                                    else
                                        push(pos_x[pi[k]], pos_y[pi[k]], pos_z[pi[k]],
                                             fn[0], fn[1], fn[2], k == 2, offt_pkg::ST_OK);
                            end
                            prev_p = p; prev_n = n; prev_nv = hn;
                            if (vert_cnt < 3) vert_cnt++;
                        end
                    end
                    if (eof)
                    begin
                        if (vert_cnt < 3) push(0, 0, 0, 0, 0, 0, 0, offt_pkg::ST_SHORT);
                        clear_face();
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string fld, longint exp_v, longint act_v);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, act_v);
            errors++;
        endfunction

        function void check_corner(corner_t got);
            corner_t e;
            if (corners_due.size() == 0)
            begin
                $display("%0t: unexpected word, status %0d", $time, got.status);
                errors++;
                return;
            end
            e = corners_due.pop_front();
            if (got.x !== e.x) report("vertex_x", e.x, got.x);
            if (got.y !== e.y) report("vertex_y", e.y, got.y);
            if (got.z !== e.z) report("vertex_z", e.z, got.z);
            if (got.nx !== e.nx) report("normal_out_x", e.nx, got.nx);
            if (got.ny !== e.ny) report("normal_out_y", e.ny, got.ny);
            if (got.nz !== e.nz) report("normal_out_z", e.nz, got.nz);
            if (got.tend !== e.tend) report("triangle_end", e.tend, got.tend);
            if (got.status !== e.status) report("status", e.status, got.status);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    offt_in_if  in_if();
    offt_out_if out_if();

    obj_face_fan_triangulator_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if)
    );

    fan_scoreboard sb = new();
    int  burst_left;
    int  tb_pos_cnt, tb_nrm_cnt;
    int  items_sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: stall pattern changes mode every so often
    int ready_mode = 0;
    int mode_left = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        else
            mode_left--;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
            case (ready_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= $urandom_range(0, 1);
                default: out_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        corner_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got.x = out_if.vertex_x; got.y = out_if.vertex_y; got.z = out_if.vertex_z;
            got.nx = out_if.normal_out_x; got.ny = out_if.normal_out_y;
            got.nz = out_if.normal_out_z;
            got.tend = out_if.triangle_end;
            got.status = out_if.status;
            sb.check_corner(got);
        end
    end

    // hand one word to the block, idling between bursts
    task automatic send_word(logic [1:0] cmd, int cx, int cy, int cz,
                             logic signed [13:0] pidx, bit hn,
                             logic signed [13:0] nidx, bit eof);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.cmd         <= cmd;
        in_if.coord_x     <= cx;
        in_if.coord_y     <= cy;
        in_if.coord_z     <= cz;
        in_if.pos_index   <= pidx;
        in_if.has_normal  <= hn;
        in_if.norm_index  <= nidx;
        in_if.end_of_face <= eof;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_item(cmd, cx, cy, cz, pidx, hn, nidx, eof);
        items_sent++;
        if (cmd == offt_pkg::CMD_ADD_POS && tb_pos_cnt < offt_pkg::POS_DEPTH) tb_pos_cnt++;
        if (cmd == offt_pkg::CMD_ADD_NORM && tb_nrm_cnt < offt_pkg::NORM_DEPTH) tb_nrm_cnt++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.corners_due.size() != 0) @(posedge clk);
    endtask

    function automatic int rnd_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2:       return (int'($urandom_range(0, 16)) - 8) * 65536;
            3:       return 0;
            default: return int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
        endcase
    endfunction

    function automatic logic signed [13:0] pick_index(int cnt, bit bad);
        if (bad || cnt == 0)
            case ($urandom_range(0, 3))
                0:       return 14'sd0;
                1:       return 14'(cnt + $urandom_range(1, 50));
                2:       return -14'(cnt + $urandom_range(1, 50));
                default: return 14'($urandom);
            endcase
        else if ($urandom_range(0, 1))
            return 14'($urandom_range(1, cnt));
        else
            return -14'($urandom_range(1, cnt));
    endfunction

    task automatic add_pos(int x, int y, int z);
        send_word(offt_pkg::CMD_ADD_POS, x, y, z, 0, 0, 0, 0);
    endtask

    task automatic add_nrm(int x, int y, int z);
        send_word(offt_pkg::CMD_ADD_NORM, x, y, z, 0, 0, 0, 0);
    endtask

    task automatic face_vtx(int p, bit hn, int n, bit eof);
        send_word(offt_pkg::CMD_FACE, 0, 0, 0, 14'(p), hn, 14'(n), eof);
    endtask

    task automatic random_face();
        int  nv, mode;
        bit  hn, bad;
        nv = $urandom_range(1, 6);
        mode = $urandom_range(0, 2);
        for (int v = 0; v < nv; v++)
        begin
            hn  = (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : $urandom_range(0, 1);
            bad = ($urandom_range(0, 24) == 0);
            send_word(offt_pkg::CMD_FACE, $urandom, $urandom, $urandom,
                      pick_index(tb_pos_cnt, bad && $urandom_range(0, 1)), hn,
                      pick_index(tb_nrm_cnt, bad), v == nv - 1);
        end
    endtask

    initial
    begin
        int r;
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.cmd         = offt_pkg::CMD_ADD_POS;
        in_if.coord_x     = 0;
        in_if.coord_y     = 0;
        in_if.coord_z     = 0;
        in_if.pos_index   = 0;
        in_if.has_normal  = 1'b0;
        in_if.norm_index  = 0;
        in_if.end_of_face = 1'b0;
        burst_left        = 0;
        sb.pos_cnt = 0; sb.nrm_cnt = 0; sb.errors = 0;
        sb.clear_face();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: face before any store, extremes, every status but a full store
        face_vtx(1, 0, 0, 1);
        add_pos(0, 0, 0);
        add_pos(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_pos(32'h8000_0000, 32'h7fff_ffff, 0);
        add_pos(65536, 0, 0);
        add_pos(0, 65536, 0);
        add_nrm(32'h7fff_ffff, 32'h8000_0000, 0);
        add_nrm(0, 0, 65536);
        face_vtx(1, 0, 0, 0);
        face_vtx(4, 0, 0, 0);
        face_vtx(5, 0, 0, 1);
        face_vtx(1, 1, 1, 0);
        face_vtx(2, 1, 2, 0);
        face_vtx(-1, 1, -2, 0);
        face_vtx(-2, 0, 0, 1);
        face_vtx(1, 0, 0, 0);
        face_vtx(1, 0, 0, 0);
        face_vtx(4, 0, 0, 1);
        face_vtx(1, 0, 0, 0);
        face_vtx(0, 0, 0, 0);
        face_vtx(2, 0, 0, 1);
        face_vtx(1, 1, 3, 0);
        face_vtx(2, 0, 0, 1);
        face_vtx(3, 0, 0, 1);
        send_word(2'd3, 0, 0, 0, 0, 0, 0, 1);

        // random part, with a full drain half-way
        while (items_sent < 460)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                add_pos(rnd_coord(), rnd_coord(), rnd_coord());
            else if (r < 25)
                add_nrm(rnd_coord(), rnd_coord(), rnd_coord());
            else if (r < 28)
                send_word(2'd3, $urandom, $urandom, $urandom, 14'($urandom),
                          $urandom_range(0, 1), 14'($urandom), $urandom_range(0, 1));
            else
                random_face();
            if (items_sent > 240 && items_sent < 250) drain();
        end

        in_if.valid <= 1'b0;
        while (sb.corners_due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.corners_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
